// ===== src/adsr_pkg.sv =====
// Shared constants, register indexes, stage codes and helpers of the ADSR envelope block.
`default_nettype none
package adsr_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int LEVEL_WIDTH_DEF = 16;

  // widths of the configuration registers
  localparam int DUR_W      = 24;
  localparam int CFG_LVL_W  = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd4;

  // reset values
  localparam logic [DUR_W-1:0]     ATTACK_RST  = 24'd9600;
  localparam logic [DUR_W-1:0]     DECAY_RST   = 24'd9600;
  localparam logic [CFG_LVL_W-1:0] SUSTAIN_RST = 16'd26214;
  localparam logic [DUR_W-1:0]     RELEASE_RST = 24'd19200;
  localparam logic [CFG_LVL_W-1:0] PEAK_RST    = 16'd32768;

  // stage codes
  localparam int STAGE_W = 3;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd0;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd2;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd3;
  localparam logic [STAGE_W-1:0] ST_SILENT  = 3'd4;

  // a zero duration acts as one tick
  function automatic logic [DUR_W-1:0] nz_ticks(input logic [DUR_W-1:0] t);
    nz_ticks = (t == '0) ? DUR_W'(1) : t;
  endfunction

endpackage
`default_nettype wire

// ===== src/adsr_in_if.sv =====
// Input channel: note timing word with valid/ready handshake.
`default_nettype none
interface adsr_in_if #(
  parameter int TW = 32
);
  logic          valid;
  logic          ready;
  logic [TW-1:0] sample_time;
  logic [TW-1:0] note_on_time;
  logic [TW-1:0] note_off_time;

  modport source (output valid, sample_time, note_on_time, note_off_time, input ready);
  modport sink   (input valid, sample_time, note_on_time, note_off_time, output ready);
endinterface
`default_nettype wire

// ===== src/adsr_out_if.sv =====
// Result channel: envelope level and stage with valid/ready handshake.
`default_nettype none
interface adsr_out_if #(
  parameter int LW = 16
);
  logic          valid;
  logic          ready;
  logic [LW-1:0] amplitude;
  logic [2:0]    stage;

  modport source (output valid, amplitude, stage, input ready);
  modport sink   (input valid, amplitude, stage, output ready);
endinterface
`default_nettype wire

// ===== src/adsr_envelope_level.sv =====
// Top level of the linear ADSR envelope level pipeline.
//
// Stateless envelope evaluator: each input word carries the current tick and
// the note-on/note-off ticks, each result word the Q1.(LEVEL_WIDTH-1) level
// and stage code (0 attack, 1 decay, 2 sustain, 3 release, 4 silent). The
// note counts as held while note_on_time is later than note_off_time. One
// word is accepted per clock while the output is not back-pressured; the two
// chained bit-per-stage dividers give first the held level, then scale it
// down for release. Every stage holds its word when the one ahead is full,
// so bubbles close up and a full output register does not block input until
// the pipe is full. Registers are to be written through cfg_* only while no
// word is in flight; the block does not enforce it. Unused indexes are ignored.
`default_nettype none
module adsr_envelope_level
  import adsr_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  adsr_in_if.sink                    in_word,
  adsr_out_if.source                 out_word
);
  localparam int TW  = TIME_WIDTH;
  localparam int LW  = LEVEL_WIDTH;
  // compare width for times against 24-bit durations
  localparam int XW  = (TW > DUR_W) ? TW : DUR_W;
  localparam int NW  = DUR_W + LW;
  // levels at or below 0.0001 full scale are silenced
  localparam logic [LW-1:0] SILENCE = LW'((64'd1 << (LW - 1)) / 64'd10000);

  localparam int SB1_W = 2 + TW + STAGE_W + LW + 1;
  localparam int SB2_W = 2 + LW + STAGE_W + 1;

  // ---------------- configuration registers ----------------
  logic [DUR_W-1:0]     attack_r, decay_r, release_r;
  logic [CFG_LVL_W-1:0] sustain_r, peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      decay_r   <= DECAY_RST;
      sustain_r <= SUSTAIN_RST;
      release_r <= RELEASE_RST;
      peak_r    <= PEAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_data;
        REG_DECAY:   decay_r   <= cfg_data;
        REG_SUSTAIN: sustain_r <= cfg_data[CFG_LVL_W-1:0];
        REG_RELEASE: release_r <= cfg_data;
        REG_PEAK:    peak_r    <= cfg_data[CFG_LVL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DUR_W-1:0] a_t, d_t, rel_t;
  logic [LW-1:0]    pk, su;
  assign a_t   = nz_ticks(attack_r);
  assign d_t   = nz_ticks(decay_r);
  assign rel_t = nz_ticks(release_r);
  assign pk    = LW'(peak_r);
  assign su    = LW'(sustain_r);

  // ---------------- ready chain ----------------
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g;
  logic d1_in_rdy, d1_out_v, d2_in_rdy, d2_out_v;

  assign rdy_g = !vg_r || out_word.ready;
  assign rdy_f = !vf_r || d2_in_rdy;
  assign rdy_e = !ve_r || rdy_f;
  assign rdy_d = !vd_r || d1_in_rdy;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_word.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_word.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= d1_out_v;
      if (rdy_f) vf_r <= ve_r;
      if (rdy_g) vg_r <= d2_out_v;
    end
  end

  // ---------------- A: input register ----------------
  logic [TW-1:0] now_r, on_r, off_r;
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      now_r <= in_word.sample_time;
      on_r  <= in_word.note_on_time;
      off_r <= in_word.note_off_time;
    end
  end

  // ---------------- B: lifetimes ----------------
  logic          b_held_r, b_neg_r;
  logic [TW-1:0] b_life_r, b_e_r;
  logic          b_held;
  assign b_held = on_r > off_r;

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_held_r <= b_held;
      b_neg_r  <= b_held && (now_r < on_r);
      // held: time since press; released: how long it was held
      b_life_r <= b_held ? now_r - on_r : off_r - on_r;
      b_e_r    <= (now_r < off_r) ? '0 : now_r - off_r;
    end
  end

  // ---------------- C: stage pick, divider operands ----------------
  logic [XW-1:0] lifex, tx;
  logic          c_att, c_dec;
  assign lifex = XW'(b_life_r);
  assign tx    = lifex - XW'(a_t);
  assign c_att = lifex <= XW'(a_t);
  assign c_dec = !c_att && (tx <= XW'(d_t));

  logic               c_held_r, c_neg_r, c_sub_r;
  logic [TW-1:0]      c_e_r;
  logic [STAGE_W-1:0] c_stg_r;
  logic [DUR_W-1:0]   c_ma_r, c_den_r;
  logic [LW-1:0]      c_mb_r, c_base_r;

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_held_r <= b_held_r;
      c_neg_r  <= b_neg_r;
      c_e_r    <= b_e_r;
      priority if (c_att) begin
        c_stg_r  <= ST_ATTACK;
        c_ma_r   <= lifex[DUR_W-1:0];
        c_mb_r   <= pk;
        c_den_r  <= a_t;
        c_base_r <= '0;
        c_sub_r  <= 1'b0;
      end else if (c_dec) begin
        // decay moves towards sustain from either side
        c_stg_r  <= ST_DECAY;
        c_ma_r   <= tx[DUR_W-1:0];
        c_mb_r   <= (su >= pk) ? su - pk : pk - su;
        c_den_r  <= d_t;
        c_base_r <= pk;
        c_sub_r  <= su < pk;
      end else begin
        c_stg_r  <= ST_SUSTAIN;
        c_ma_r   <= '0;
        c_mb_r   <= '0;
        c_den_r  <= DUR_W'(1);
        c_base_r <= su;
        c_sub_r  <= 1'b0;
      end
    end
  end

  // ---------------- D: product for held level ----------------
  logic [NW-1:0]    d_num_r;
  logic [DUR_W-1:0] d_den_r;
  logic [SB1_W-1:0] d_sb_r;
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_num_r <= NW'(c_ma_r) * NW'(c_mb_r);
      d_den_r <= c_den_r;
      d_sb_r  <= {c_held_r, c_neg_r, c_e_r, c_stg_r, c_base_r, c_sub_r};
    end
  end

  logic [LW-1:0]    q1;
  logic [SB1_W-1:0] sb1;

  adsr_div #(
    .DEN_W (DUR_W),
    .Q_W   (LW),
    .SB_W  (SB1_W)
  ) u_div_held (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vd_r),
    .in_ready  (d1_in_rdy),
    .in_num    (d_num_r),
    .in_den    (d_den_r),
    .in_sb     (d_sb_r),
    .out_valid (d1_out_v),
    .out_ready (rdy_e),
    .out_q     (q1),
    .out_sb    (sb1)
  );

  // ---------------- E: held level, release operands ----------------
  logic               s1_held, s1_neg, s1_sub;
  logic [TW-1:0]      s1_e;
  logic [STAGE_W-1:0] s1_stg;
  logic [LW-1:0]      s1_base;
  assign {s1_held, s1_neg, s1_e, s1_stg, s1_base, s1_sub} = sb1;

  logic [XW-1:0] ex;
  assign ex = XW'(s1_e);

  logic               e_held_r, e_neg_r, e_ge_r;
  logic [STAGE_W-1:0] e_stg_r;
  logic [LW-1:0]      e_lvl_r;
  logic [DUR_W-1:0]   e_diff_r;
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      e_held_r <= s1_held;
      e_neg_r  <= s1_neg;
      e_stg_r  <= s1_stg;
      e_lvl_r  <= s1_sub ? s1_base - q1 : s1_base + q1;
      // release finished once elapsed reaches the release length
      e_ge_r   <= ex >= XW'(rel_t);
      e_diff_r <= rel_t - ex[DUR_W-1:0];
    end
  end

  // ---------------- F: product for release level ----------------
  logic [NW-1:0]    f_num_r;
  logic [DUR_W-1:0] f_den_r;
  logic [SB2_W-1:0] f_sb_r;
  always_ff @(posedge clk) begin
    if (rdy_f) begin
      f_num_r <= NW'(e_lvl_r) * NW'(e_diff_r);
      f_den_r <= rel_t;
      f_sb_r  <= {e_held_r, e_neg_r, e_lvl_r, e_stg_r, e_ge_r};
    end
  end

  logic [LW-1:0]    q2;
  logic [SB2_W-1:0] sb2;

  adsr_div #(
    .DEN_W (DUR_W),
    .Q_W   (LW),
    .SB_W  (SB2_W)
  ) u_div_rel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vf_r),
    .in_ready  (d2_in_rdy),
    .in_num    (f_num_r),
    .in_den    (f_den_r),
    .in_sb     (f_sb_r),
    .out_valid (d2_out_v),
    .out_ready (rdy_g),
    .out_q     (q2),
    .out_sb    (sb2)
  );

  // ---------------- G: select, silence, output register ----------------
  logic               s2_held, s2_neg, s2_ge;
  logic [LW-1:0]      s2_lvl;
  logic [STAGE_W-1:0] s2_stg;
  assign {s2_held, s2_neg, s2_lvl, s2_stg, s2_ge} = sb2;

  logic [LW-1:0] g_raw, g_lvl;
  always_comb begin
    if (s2_held) begin
      g_raw = s2_neg ? '0 : s2_lvl;
    end else begin
      g_raw = s2_ge ? '0 : q2;
    end
    g_lvl = (g_raw <= SILENCE) ? '0 : g_raw;
  end

  logic [LW-1:0]      g_amp_r;
  logic [STAGE_W-1:0] g_stg_r;
  always_ff @(posedge clk) begin
    if (rdy_g) begin
      g_amp_r <= g_lvl;
      priority if (s2_held) begin
        // before note-on counts as attack at zero
        g_stg_r <= s2_neg ? ST_ATTACK : s2_stg;
      end else if (g_lvl == '0) begin
        g_stg_r <= ST_SILENT;
      end else begin
        g_stg_r <= ST_RELEASE;
      end
    end
  end

  assign out_word.valid     = vg_r;
  assign out_word.amplitude = g_amp_r;
  assign out_word.stage     = g_stg_r;
endmodule
`default_nettype wire

// ===== src/adsr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module adsr_div #(
  parameter int DEN_W = 24,
  parameter int Q_W   = 16,
  parameter int SB_W  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [DEN_W+Q_W-1:0]   in_num,
  input  wire logic [DEN_W-1:0]       in_den,
  input  wire logic [SB_W-1:0]        in_sb,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [Q_W-1:0]              out_q,
  output logic [SB_W-1:0]             out_sb
);
  localparam int NUM_W = DEN_W + Q_W;

  // numerator must stay below den * 2^Q_W
  logic             v_r   [Q_W];
  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];
  logic             rdy   [Q_W];

  genvar k;
  generate
    for (k = 0; k < Q_W; k++) begin : g_st
      localparam int B = Q_W - 1 - k;
      logic             v_i;
      logic [NUM_W-1:0] rem_i;
      logic [DEN_W-1:0] den_i;
      logic [Q_W-1:0]   q_i;
      logic [SB_W-1:0]  sb_i;
      logic [NUM_W-1:0] dsh;
      logic             take;

      if (k == 0) begin : g_first
        assign v_i   = in_valid;
        assign rem_i = in_num;
        assign den_i = in_den;
        assign q_i   = '0;
        assign sb_i  = in_sb;
      end else begin : g_next
        assign v_i   = v_r[k-1];
        assign rem_i = rem_r[k-1];
        assign den_i = den_r[k-1];
        assign q_i   = q_r[k-1];
        assign sb_i  = sb_r[k-1];
      end

      if (k == Q_W - 1) begin : g_last_rdy
        assign rdy[k] = !v_r[k] || out_ready;
      end else begin : g_mid_rdy
        assign rdy[k] = !v_r[k] || rdy[k+1];
      end

      assign dsh  = NUM_W'(den_i) << B;
      assign take = rem_i >= dsh;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_i;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_r[k] <= take ? rem_i - dsh : rem_i;
          den_r[k] <= den_i;
          q_r[k]   <= q_i | (take ? (Q_W'(1) << B) : '0);
          sb_r[k]  <= sb_i;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v_r[Q_W-1];
  assign out_q     = q_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];
endmodule
`default_nettype wire

// ===== test/tb_adsr_envelope_level.sv =====
// Self-checking bench for the ADSR envelope level block: random and directed note timings.
`timescale 1ns / 1ps
`default_nettype none
module tb_adsr_envelope_level;
  import adsr_pkg::*;

  localparam int TW        = 32;
  localparam int LW        = 16;
  localparam int HALF_NS   = 6;
  localparam int RST_CYC   = 8;
  localparam int SETTLE    = 60;    // longer than the pipe
  localparam int STALL_LIM = 3000;  // cycles with no word moving
  localparam int N_PHASE   = 8;
  localparam int PER_PHASE = 205;
  localparam logic [63:0] QUIET_LVL = 64'd3;  // levels at or below this read as silence

  typedef struct packed {
    logic [TW-1:0] now;
    logic [TW-1:0] on;
    logic [TW-1:0] off;
  } note_word_t;

  typedef struct packed {
    logic [LW-1:0]      amp;
    logic [STAGE_W-1:0] stage;
  } level_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adsr_in_if  #(.TW(TW)) in_w ();
  adsr_out_if #(.LW(LW)) out_w ();

  adsr_envelope_level #(.TIME_WIDTH(TW), .LEVEL_WIDTH(LW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (in_w),
    .out_word (out_w)
  );

  always #(HALF_NS) clk = ~clk;

  // bench copy of the envelope registers, kept in step with cfg writes
  logic [DUR_W-1:0]     atk_q = ATTACK_RST;
  logic [DUR_W-1:0]     dcy_q = DECAY_RST;
  logic [CFG_LVL_W-1:0] sus_q = SUSTAIN_RST;
  logic [DUR_W-1:0]     rel_q = RELEASE_RST;
  logic [CFG_LVL_W-1:0] pk_q  = PEAK_RST;

  note_word_t  notes_q[$];      // words waiting to be sent
  level_word_t levels_due[$];   // levels owed by the block, oldest first
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  in_fire = 1'b0;
  bit  out_fire = 1'b0;
  bit  calm = 1'b0;            // no gaps or stalls in this phase
  bit  hold_off = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;

  function automatic logic [63:0] ticks_or_one(input logic [DUR_W-1:0] t);
    return (t == '0) ? 64'd1 : {40'd0, t};
  endfunction

  // held envelope at a given lifetime
  function automatic logic [63:0] held_amp(input logic [63:0] life,
                                           output logic [STAGE_W-1:0] st);
    logic [63:0] a, d, pk, su, t;
    a  = ticks_or_one(atk_q);
    d  = ticks_or_one(dcy_q);
    pk = {48'd0, pk_q};
    su = {48'd0, sus_q};
    if (life <= a) begin
      st = ST_ATTACK;
      return (life * pk) / a;
    end
    if (life - a <= d) begin
      t  = life - a;
      st = ST_DECAY;
      if (su >= pk) return pk + (t * (su - pk)) / d;
      return pk - (t * (pk - su)) / d;
    end
    st = ST_SUSTAIN;
    return su;
  endfunction

  function automatic level_word_t envelope_of(input note_word_t w);
    level_word_t r;
    logic [63:0] lvl, rel, rl, e;
    logic [STAGE_W-1:0] st, unused_st;
    if (w.on > w.off) begin
      if (w.now < w.on) begin
        lvl = 0;
        st  = ST_ATTACK;
      end else begin
        lvl = held_amp({32'd0, w.now - w.on}, st);
      end
    end else begin
      rel = ticks_or_one(rel_q);
      rl  = held_amp({32'd0, w.off - w.on}, unused_st);
      e   = (w.now < w.off) ? 64'd0 : {32'd0, w.now - w.off};
      st  = ST_RELEASE;
      lvl = (e >= rel) ? 64'd0 : (rl * (rel - e)) / rel;
    end
    lvl = lvl & 64'hFFFF;
    if (lvl <= QUIET_LVL) lvl = 0;
    if (st == ST_RELEASE && lvl == 0) st = ST_SILENT;
    r.amp   = lvl[LW-1:0];
    r.stage = st;
    return r;
  endfunction

  // --- sampling at the rising edge: cfg shadow, predictor, checker, watchdog ---
  always @(posedge clk) begin
    level_word_t got, want;
    in_fire  <= rst_n && in_w.valid && in_w.ready;
    out_fire <= rst_n && out_w.valid && out_w.ready;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  atk_q <= cfg_data;
        REG_DECAY:   dcy_q <= cfg_data;
        REG_SUSTAIN: sus_q <= cfg_data[CFG_LVL_W-1:0];
        REG_RELEASE: rel_q <= cfg_data;
        REG_PEAK:    pk_q  <= cfg_data[CFG_LVL_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_w.valid && in_w.ready)
      levels_due.push_back(envelope_of('{in_w.sample_time, in_w.note_on_time,
                                         in_w.note_off_time}));
    if (rst_n && out_w.valid && out_w.ready) begin
      got.amp   = out_w.amplitude;
      got.stage = out_w.stage;
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: amp %0d stage %0d", got.amp, got.stage);
      end else begin
        want = levels_due.pop_front();
        if (got.amp !== want.amp || got.stage !== want.stage) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: amp exp %0d got %0d, stage exp %0d got %0d",
                     want.amp, got.amp, want.stage, got.stage);
        end
      end
    end
    // watchdog: no word moving for too long
    if (rst_n && !(in_w.valid && in_w.ready) && !(out_w.valid && out_w.ready)) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIM) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // --- driver: changes inputs at the falling edge ---
  always @(negedge clk) begin
    note_word_t w;
    if (!rst_n) begin
      in_w.valid <= 1'b0;
    end else if (!in_w.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_w.valid <= 1'b0;
      end else if (notes_q.size() != 0 && !hold_off) begin
        w = notes_q.pop_front();
        in_w.sample_time   <= w.now;
        in_w.note_on_time  <= w.on;
        in_w.note_off_time <= w.off;
        in_w.valid         <= 1'b1;
        gap_left = calm ? 0 : $urandom_range(0, 19);
      end else begin
        in_w.valid <= 1'b0;
      end
    end
  end

  // --- result sink: random back-pressure per word ---
  always @(negedge clk) begin
    if (out_fire) stall_left = calm ? 0 : $urandom_range(0, 19);
    if (stall_left > 0) begin
      stall_left--;
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= rst_n;
    end
  end

  task automatic push_note(input logic [TW-1:0] now, input logic [TW-1:0] on,
                           input logic [TW-1:0] off);
    notes_q.push_back('{now, on, off});
  endtask

  // lifetime spread over and after the held stages, boundaries included
  function automatic logic [TW-1:0] pick_life();
    logic [63:0] a, d;
    a = ticks_or_one(atk_q);
    d = ticks_or_one(dcy_q);
    case ($urandom_range(0, 7))
      0: return a[TW-1:0];
      1: return TW'(a + d);
      2: return TW'(a + 1);
      3: return $urandom_range(0, 32'(a));
      4: return TW'(a + $urandom_range(0, 32'(d)));
      5: return TW'(a + d + $urandom_range(1, 32'(d) + 100));
      6: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_note();
    logic [TW-1:0] on, off, now, rel;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    rel  = TW'(ticks_or_one(rel_q));
    on   = $urandom;
    if (pick == 0) begin
      push_note($urandom, $urandom, $urandom);  // pure noise
    end else if (pick <= 5) begin
      if (on == 0) on = 1;
      off = $urandom_range(0, on - 1);
      now = ($urandom_range(0, 9) == 0) ? on - $urandom_range(1, 1000) : on + pick_life();
      push_note(now, on, off);
    end else begin
      off = on + pick_life();
      case ($urandom_range(0, 5))
        0:       now = off - $urandom_range(1, 1000);
        1:       now = off + rel;
        2:       now = off + rel - 1;
        default: now = off + $urandom_range(0, rel + rel / 4);
      endcase
      push_note(now, on, off);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic wait_drained();
    wait (notes_q.size() == 0 && !in_w.valid && levels_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  logic [DUR_W-1:0]     atk_tab[N_PHASE] = '{24'd9600, 24'd0, 24'd1, 24'hFFFFFF,
                                              24'd100, 24'd37, 24'd0, 24'd0};
  logic [DUR_W-1:0]     dcy_tab[N_PHASE] = '{24'd9600, 24'd0, 24'd1, 24'hFFFFFF,
                                              24'd300, 24'd2000, 24'd0, 24'd0};
  logic [CFG_LVL_W-1:0] sus_tab[N_PHASE] = '{16'd26214, 16'hFFFF, 16'd0, 16'd0,
                                              16'd40000, 16'd100, 16'd0, 16'd0};
  logic [DUR_W-1:0]     rel_tab[N_PHASE] = '{24'd19200, 24'd0, 24'd1, 24'hFFFFFF,
                                              24'd500, 24'd64, 24'd0, 24'd0};
  logic [CFG_LVL_W-1:0] pk_tab[N_PHASE]  = '{16'd32768, 16'hFFFF, 16'hFFFF, 16'd1,
                                              16'd1000, 16'd0, 16'd0, 16'd0};

  initial begin
    in_w.valid         = 1'b0;
    in_w.sample_time   = '0;
    in_w.note_on_time  = '0;
    in_w.note_off_time = '0;
    out_w.ready        = 1'b0;
    repeat (RST_CYC) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed words at reset settings: attack 9600, decay 9600, release 19200
    push_note(32'd100, 32'd200, 32'd0);             // held, time before note on
    push_note(32'd200, 32'd200, 32'd0);             // held, lifetime zero
    push_note(32'd9800, 32'd200, 32'd0);            // end of attack
    push_note(32'd14600, 32'd200, 32'd0);           // mid decay
    push_note(32'd19400, 32'd200, 32'd0);           // end of decay
    push_note(32'd90000, 32'd200, 32'd0);           // sustain
    push_note(32'd200, 32'd200, 32'd201);           // released one tick after press: silent
    push_note(32'd201, 32'd200, 32'd201);           // released near zero: silent
    push_note(32'd5000, 32'd1000, 32'd6000);        // release, time before note off
    push_note(32'd6000, 32'd1000, 32'd6000);        // release start
    push_note(32'd16000, 32'd1000, 32'd6000);       // mid release
    push_note(32'd25199, 32'd1000, 32'd6000);       // last release tick
    push_note(32'd25200, 32'd1000, 32'd6000);       // release finished
    push_note(32'd25190, 32'd1000, 32'd50000);      // released from sustain, time before note off
    push_note(32'h0, 32'h0, 32'h0);                 // all zero
    push_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0); // held at the top of time
    push_note(32'h0, 32'hFFFF_FFFF, 32'h0);         // held, now far before on
    push_note(32'hFFFF_FFFF, 32'h0, 32'h0);         // released long ago
    push_note(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF); // release from sustain, e zero
    push_note(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_note(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

    for (int p = 0; p < N_PHASE; p++) begin
      wait_drained();
      if (p > 0) begin
        if (p == 6) begin
          atk_tab[p] = DUR_W'($urandom_range(1, 5000));
          dcy_tab[p] = DUR_W'($urandom_range(1, 5000));
          rel_tab[p] = DUR_W'($urandom_range(1, 5000));
          sus_tab[p] = CFG_LVL_W'($urandom);
          pk_tab[p]  = CFG_LVL_W'($urandom);
        end else if (p == 7) begin
          atk_tab[p] = DUR_W'($urandom);
          dcy_tab[p] = DUR_W'($urandom);
          rel_tab[p] = DUR_W'($urandom);
          sus_tab[p] = CFG_LVL_W'($urandom);
          pk_tab[p]  = CFG_LVL_W'($urandom);
        end
        write_reg(REG_ATTACK, atk_tab[p]);
        write_reg(REG_DECAY, dcy_tab[p]);
        write_reg(REG_SUSTAIN, CFG_DATA_W'(sus_tab[p]));
        write_reg(REG_RELEASE, rel_tab[p]);
        write_reg(REG_PEAK, CFG_DATA_W'(pk_tab[p]));
        if (p == 1) begin
          // unused indexes must leave the registers alone
          write_reg(3'd5, 24'hFFFFFF);
          write_reg(3'd6, 24'h000000);
          write_reg(3'd7, 24'hA5A5A5);
        end
        @(negedge clk) cfg_we <= 1'b0;
        @(posedge clk);
      end
      calm = (p % 3 == 2);
      for (int i = 0; i < PER_PHASE; i++) begin
        random_note();
        // mid-phase: sender holds back until the pipe has emptied
        if (p == 4 && i == PER_PHASE / 2) begin
          wait (notes_q.size() == 0 && !in_w.valid);
          hold_off = 1'b1;
          random_note();
          wait (levels_due.size() == 0);
          hold_off = 1'b0;
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
